### rtl/plid_pkg.sv
package plid_pkg;

    localparam int DEF_DEPTH      = 64;
    localparam int DEF_ELEM_WIDTH = 32;
    localparam int VAL_W          = 32;   // width of the value ports
    localparam int STATUS_W       = 2;
    localparam int REQ_W          = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } t_cell_ctl;

endpackage

### rtl/plid_cell.sv
module plid_cell import plid_pkg::*; #(
    parameter int IDX        = 0,
    parameter int POS_W      = 7,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [POS_W-1:0]      i_pos,
    input  logic [ELEM_WIDTH-1:0] i_value,
    input  logic [ELEM_WIDTH-1:0] i_left,
    input  logic [ELEM_WIDTH-1:0] i_right,
    output logic [ELEM_WIDTH-1:0] o_data,
    output logic [ELEM_WIDTH-1:0] o_tap
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] n_data;
    logic [ELEM_WIDTH-1:0] r_tap;
    logic [ELEM_WIDTH-1:0] n_tap;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && (MY_POS > i_pos)) begin
            n_data = i_left;
        end else if (i_ctl.ins && (MY_POS == i_pos)) begin
            n_data = i_value;
        end else if (i_ctl.del && (MY_POS >= i_pos)) begin
            n_data = i_right;
        end
    end

    // tap is zero unless this cell is the one being read
    assign n_tap = (i_ctl.rd && (MY_POS == i_pos)) ? r_data : '0;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

### rtl/positional_list_insert_delete_unit.sv
// Positional list insert/delete unit.
//
// Keeps an ordered list of up to DEPTH signed words in a row of cells plus
// a fill count. Requests come in on i_start/i_req_type/i_position/i_value
// and are taken at any rising edge with i_start high and o_busy low.
//   insert: word goes to position 0..count, later words move up one cell
//   delete: word at position < count is removed, later words move down
//   read:   word at position < count is returned on o_read_value
// Every request yields one result word: o_status (ok, full, bad position),
// o_count (count after the request) and o_read_value (0 unless a good read).
// The result is shown for one cycle with o_valid; the receiver cannot stall
// it and must take it in that cycle.
// o_valid comes from r_s1_valid then r_valid. Throughput: one request per
// cycle while o_busy is low; every cell moves its word in the accept cycle,
// and the read word goes through the cell tap registers and one OR reduction
// over the row. Reset (i_rst_n low, synchronous) empties the list and drops
// o_valid; o_busy is high during reset and for the first cycle after it.
module positional_list_insert_delete_unit import plid_pkg::*; #(
    parameter int  DEPTH      = DEF_DEPTH,
    parameter int  ELEM_WIDTH = DEF_ELEM_WIDTH,
    localparam int POS_W      = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic [POS_W-1:0]        o_count,
    output logic signed [VAL_W-1:0] o_read_value
);

    localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

    logic                  r_alive;
    logic [POS_W-1:0]      r_fill;
    logic [POS_W-1:0]      n_fill;
    logic                  r_s1_valid;
    t_status               r_s1_status;
    t_status               n_status;
    t_cell_ctl             n_ctl;
    logic                  w_acc;

    logic                  r_valid;
    t_status               r_status;
    logic [POS_W-1:0]      r_count;
    logic [VAL_W-1:0]      r_rdata;

    logic [ELEM_WIDTH-1:0] w_store;
    logic [ELEM_WIDTH-1:0] w_data [DEPTH];
    logic [ELEM_WIDTH-1:0] w_tap  [DEPTH];
    logic [ELEM_WIDTH-1:0] w_rd_or;
    logic [VAL_W-1:0]      w_rd_val;

    assign w_acc  = i_start & r_alive;
    assign o_busy = ~r_alive;

    // value port <-> cell width: low bits kept, upper bits zero-filled
    generate
        if (ELEM_WIDTH <= VAL_W) begin : g_narrow
            assign w_store = i_value[ELEM_WIDTH-1:0];
        end else begin : g_wide
            assign w_store = {{(ELEM_WIDTH - VAL_W){1'b0}}, i_value};
        end
        if (ELEM_WIDTH >= VAL_W) begin : g_rd_trunc
            assign w_rd_val = w_rd_or[VAL_W-1:0];
        end else begin : g_rd_ext
            assign w_rd_val = {{(VAL_W - ELEM_WIDTH){1'b0}}, w_rd_or};
        end
    endgenerate

    // request decode: status, fill update and the command for the cell row.
    // Full is checked before position on insert; a rejected request is a no-op.
    always_comb begin
        n_ctl    = '0;
        n_status = ST_BADPOS;
        n_fill   = r_fill;
        if (w_acc) begin
            case (t_req'(i_req_type))
                REQ_INSERT: begin
                    if (r_fill == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else if (i_position > r_fill) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_status  = ST_OK;
                        n_ctl.ins = 1'b1;
                        n_fill    = r_fill + POS_W'(1);
                    end
                end
                REQ_DELETE: begin
                    if (i_position >= r_fill) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_status  = ST_OK;
                        n_ctl.del = 1'b1;
                        n_fill    = r_fill - POS_W'(1);
                    end
                end
                REQ_READ: begin
                    if (i_position >= r_fill) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_status = ST_OK;
                        n_ctl.rd = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_BADPOS;
                end
            endcase
        end
    end

    // cell row: cell i sees cell i-1 on the left and cell i+1 on the right;
    // the end cells loop their own word back in place of a missing neighbor
    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ELEM_WIDTH-1:0] w_left;
            logic [ELEM_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_data[gi];
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_data[gi];
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end
            plid_cell #(
                .IDX        (gi),
                .POS_W      (POS_W),
                .ELEM_WIDTH (ELEM_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (n_ctl),
                .i_pos   (i_position),
                .i_value (w_store),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[gi]),
                .o_tap   (w_tap[gi])
            );
        end
    endgenerate

    // at most one tap is nonzero, so an OR over the row picks the read word
    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_or = w_rd_or | w_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive    <= 1'b0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_alive    <= 1'b1;
            r_fill     <= n_fill;
            r_s1_valid <= w_acc;
            r_valid    <= r_s1_valid;
        end
    end

    // result payload; r_fill already holds the count after the request
    always_ff @(posedge i_clk) begin
        r_s1_status <= n_status;
        if (r_s1_valid) begin
            r_status <= r_s1_status;
            r_count  <= r_fill;
            r_rdata  <= w_rd_val;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_count      = r_count;
    assign o_read_value = r_rdata;

endmodule

### rtl/plid_chk.sv
module plid_chk import plid_pkg::*; #(
    parameter int  DEPTH      = DEF_DEPTH,
    localparam int POS_W      = $clog2(DEPTH + 1)
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_start,
    input logic                    o_busy,
    input logic                    o_valid,
    input logic [STATUS_W-1:0]     o_status,
    input logic [POS_W-1:0]        o_count,
    input logic signed [VAL_W-1:0] o_read_value
);

    localparam logic [POS_W-1:0] FULL_CNT = POS_W'(DEPTH);

    // every accepted request is followed by its result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("result missing two cycles after accept");

    // a result only ever follows an accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without a request");

    // only a good read carries a word
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_value == '0))
        else $error("nonzero word on a rejected request");

    // full is reported only when the list holds DEPTH words
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == FULL_CNT))
        else $error("full status with list not full");

    // count never exceeds the capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= FULL_CNT))
        else $error("count above capacity");

endmodule

bind positional_list_insert_delete_unit plid_chk #(
    .DEPTH (DEPTH)
) u_plid_chk (.*);

### verif/tb_positional_list_insert_delete_unit.sv
`default_nettype none

module tb_positional_list_insert_delete_unit import plid_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_DEPTH;
    localparam int POS_W = $clog2(DEPTH + 1);
    // request code outside the defined set; the block must reject it
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    // generous bound for 624 words with their idle gaps
    localparam int CYCLE_LIMIT = 50000;
    // spare cycles run after the last result has been checked
    localparam int DRAIN_CYCLES = 6;
    localparam int WORDS_PER_PHASE = 200;
    localparam int MAX_REPORTS = 10;

    // one result word as it leaves the block
    typedef struct {
        t_status                 status;
        logic [POS_W-1:0]        count;
        logic signed [VAL_W-1:0] read_value;
    } t_result_word;

    // directed row: request plus, where obvious, the result typed in
    typedef struct {
        logic [REQ_W-1:0]        req;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        bit                      typed;
        t_status                 status;
        logic [POS_W-1:0]        count;
        logic signed [VAL_W-1:0] read_value;
    } t_directed_row;

    localparam int NUM_DIRECTED = 24;

    // Walkthrough: bad requests on the empty list, build a list with the
    // value extremes, read both ends, hit every bad-position form (including
    // position all ones), delete middle/last/first, then leave one word in.
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{REQ_READ,    7'd0,   32'h1234_5678, 1'b1, ST_BADPOS, 7'd0, 32'h0},
        '{REQ_DELETE,  7'd0,   32'hDEAD_BEEF, 1'b1, ST_BADPOS, 7'd0, 32'h0},
        '{REQ_INSERT,  7'd1,   32'h0000_0001, 1'b1, ST_BADPOS, 7'd0, 32'h0},
        '{REQ_UNKNOWN, 7'd0,   32'hFFFF_FFFF, 1'b1, ST_BADPOS, 7'd0, 32'h0},
        '{REQ_INSERT,  7'd0,   32'h7FFF_FFFF, 1'b1, ST_OK,     7'd1, 32'h0},
        '{REQ_INSERT,  7'd0,   32'h8000_0000, 1'b1, ST_OK,     7'd2, 32'h0},
        '{REQ_INSERT,  7'd2,   32'hFFFF_FFFF, 1'b1, ST_OK,     7'd3, 32'h0},
        '{REQ_INSERT,  7'd1,   32'h0000_0000, 1'b1, ST_OK,     7'd4, 32'h0},
        '{REQ_READ,    7'd0,   32'h5555_5555, 1'b1, ST_OK,     7'd4, 32'h8000_0000},
        '{REQ_READ,    7'd3,   32'h0,         1'b1, ST_OK,     7'd4, 32'hFFFF_FFFF},
        '{REQ_READ,    7'd4,   32'h0,         1'b1, ST_BADPOS, 7'd4, 32'h0},
        '{REQ_DELETE,  7'd4,   32'h0,         1'b1, ST_BADPOS, 7'd4, 32'h0},
        '{REQ_INSERT,  7'd5,   32'h0000_0005, 1'b1, ST_BADPOS, 7'd4, 32'h0},
        '{REQ_INSERT,  7'd127, 32'h5555_5555, 1'b1, ST_BADPOS, 7'd4, 32'h0},
        '{REQ_READ,    7'd1,   32'h0,         1'b0, ST_OK,     7'd0, 32'h0},
        '{REQ_DELETE,  7'd1,   32'hAAAA_AAAA, 1'b0, ST_OK,     7'd0, 32'h0},
        '{REQ_READ,    7'd1,   32'h0,         1'b0, ST_OK,     7'd0, 32'h0},
        '{REQ_DELETE,  7'd2,   32'h0,         1'b0, ST_OK,     7'd0, 32'h0},
        '{REQ_READ,    7'd127, 32'h0,         1'b1, ST_BADPOS, 7'd2, 32'h0},
        '{REQ_UNKNOWN, 7'd127, 32'hAAAA_AAAA, 1'b1, ST_BADPOS, 7'd2, 32'h0},
        '{REQ_DELETE,  7'd0,   32'h0,         1'b0, ST_OK,     7'd0, 32'h0},
        '{REQ_READ,    7'd0,   32'h0,         1'b0, ST_OK,     7'd0, 32'h0},
        '{REQ_DELETE,  7'd0,   32'h0,         1'b1, ST_OK,     7'd0, 32'h0},
        '{REQ_INSERT,  7'd0,   32'hAAAA_AAAA, 1'b0, ST_OK,     7'd0, 32'h0}
    };

    // DUT ports; known values from time zero
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_start      = 1'b0;
    logic [REQ_W-1:0]        i_req_type   = '0;
    logic [POS_W-1:0]        i_position   = '0;
    logic signed [VAL_W-1:0] i_value      = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic [STATUS_W-1:0]     o_status;
    logic [POS_W-1:0]        o_count;
    logic signed [VAL_W-1:0] o_read_value;

    positional_list_insert_delete_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_read_value (o_read_value)
    );

    // shadow copy of the list, updated when a word is accepted
    logic signed [VAL_W-1:0] shadow_slots [DEPTH];
    int                      shadow_fill = 0;
    t_result_word            pending_results [$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  idle_pct    = 0;
    bit  growing     = 1'b1;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_positional_list_insert_delete_unit failed");
            $finish;
        end
    end

    // Apply one request to the shadow list and return the result it gives.
    // Full check comes before the position check on insert.
    function automatic t_result_word apply_to_shadow(
        input logic [REQ_W-1:0] req,
        input logic [POS_W-1:0] pos,
        input logic signed [VAL_W-1:0] val
    );
        t_result_word res;
        int           q;
        res.status     = ST_BADPOS;
        res.read_value = '0;
        case (req)
            REQ_INSERT: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (int'(pos) <= shadow_fill) begin
                    for (q = shadow_fill; q > int'(pos); q--)
                        shadow_slots[q] = shadow_slots[q-1];
                    shadow_slots[pos] = val;
                    shadow_fill++;
                    res.status = ST_OK;
                end
            end
            REQ_DELETE: begin
                if (int'(pos) < shadow_fill) begin
                    for (q = int'(pos); q + 1 < shadow_fill; q++)
                        shadow_slots[q] = shadow_slots[q+1];
                    shadow_fill--;
                    res.status = ST_OK;
                end
            end
            REQ_READ: begin
                if (int'(pos) < shadow_fill) begin
                    res.status     = ST_OK;
                    res.read_value = shadow_slots[pos];
                end
            end
            default: res.status = ST_BADPOS;    // unknown request
        endcase
        res.count = shadow_fill[POS_W-1:0];
        return res;
    endfunction

    // Offer one word after a random idle gap, wait for accept, then log
    // the expected result (typed one if given, else the shadow's).
    task automatic submit_word(
        input logic [REQ_W-1:0] req,
        input logic [POS_W-1:0] pos,
        input logic signed [VAL_W-1:0] val,
        input bit typed,
        input t_result_word typed_res
    );
        t_result_word predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_req_type <= req;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predicted = apply_to_shadow(req, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Random word. Grow/shrink trend sweeps the list between empty and
    // full so full-list inserts and empty-list rejects both show up.
    task automatic pick_word(
        output logic [REQ_W-1:0] req,
        output logic [POS_W-1:0] pos,
        output logic signed [VAL_W-1:0] val
    );
        int unsigned roll;
        int          top;
        if (growing && shadow_fill == DEPTH && $urandom_range(7) == 0)
            growing = 1'b0;
        else if (!growing && shadow_fill == 0 && $urandom_range(3) == 0)
            growing = 1'b1;

        roll = $urandom_range(99);
        if (roll < 68)
            req = growing ? REQ_INSERT : REQ_DELETE;
        else if (roll < 83)
            req = growing ? REQ_DELETE : REQ_INSERT;
        else if (roll < 97)
            req = REQ_READ;
        else
            req = REQ_UNKNOWN;

        // highest legal position for this request
        top = (req == REQ_INSERT) ? shadow_fill
                                  : ((shadow_fill == 0) ? 0 : shadow_fill - 1);
        roll = $urandom_range(99);
        if (roll < 8)
            pos = POS_W'($urandom_range(2**POS_W - 1));
        else if (roll < 14)
            pos = POS_W'(top + 1);
        else if (roll < 22)
            pos = '0;
        else if (roll < 30)
            pos = POS_W'(top);
        else
            pos = POS_W'($urandom_range(top));

        roll = $urandom_range(99);
        case (roll % 4)
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'hFFFF_FFFF;
            default: val = 32'h0;
        endcase
        if (roll >= 12)
            val = $urandom();
    endtask

    task automatic note_mismatch(
        input string field,
        input logic [VAL_W-1:0] want,
        input logic [VAL_W-1:0] got
    );
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %h got %h at cycle %0d",
                     field, want, got, cycle_count);
    endtask

    // result checker: strobe cannot be held off, so take it every cycle
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected word", '0, {30'd0, o_status});
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", VAL_W'(want.status), VAL_W'(o_status));
                if (o_count !== want.count)
                    note_mismatch("count", VAL_W'(want.count), VAL_W'(o_count));
                if (o_read_value !== want.read_value)
                    note_mismatch("read_value", want.read_value, o_read_value);
            end
        end
    end

    initial begin
        logic [REQ_W-1:0]        req;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        t_result_word            typed_res;
        int                      phase;
        int                      n;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        idle_pct = 28;
        for (n = 0; n < NUM_DIRECTED; n++) begin
            typed_res.status     = directed_rows[n].status;
            typed_res.count      = directed_rows[n].count;
            typed_res.read_value = directed_rows[n].read_value;
            submit_word(directed_rows[n].req, directed_rows[n].pos,
                        directed_rows[n].val, directed_rows[n].typed, typed_res);
        end

        // random: sender idles 28%, then 81%, then back to back
        typed_res = '{ST_OK, '0, '0};
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 28 : ((phase == 1) ? 81 : 0);
            repeat (WORDS_PER_PHASE) begin
                pick_word(req, pos, val);
                submit_word(req, pos, val, 1'b0, typed_res);
            end
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_positional_list_insert_delete_unit passed");
        else
            $display("tb_positional_list_insert_delete_unit failed");
        $finish;
    end

endmodule

`default_nettype wire
